/* rtl/bdpp_pkg.sv */
package bdpp_pkg;

  localparam logic [1:0] KIND_PATH    = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [1:0] STOP_LIST   = 2'd0;
  localparam logic [1:0] STOP_END    = 2'd1;
  localparam logic [1:0] STOP_LENGTH = 2'd2;

  localparam logic [7:0] TYPE_MEDIA   = 8'h04;
  localparam logic [7:0] SUB_HD       = 8'h01;
  localparam logic [7:0] SUB_FILE     = 8'h04;
  localparam logic [7:0] TYPE_END     = 8'h7f;
  localparam logic [7:0] SUB_END      = 8'hff;
  localparam logic [7:0] GPT_CODE     = 8'h02;

  // one result word, tdata order from kind up
  typedef struct packed {
    logic        run_last;
    logic [1:0]  stop_cause;
    logic        uuid_found;
    logic [63:0] uuid_low;
    logic [63:0] uuid_high;
    logic        path_first;
    logic [7:0]  path_byte;
    logic [1:0]  kind;
  } result_t;

endpackage

/* rtl/boot_device_path_parser_core.sv */
// boot device path parser
// slave channel: one byte of a boot option's device-path list per word, tlast
// on the final byte of the list. master channel: result words (path bytes,
// path finished markers, one summary per list), tlast set on the last word
// caused by an input byte.
// each input byte is decoded combinationally into a small batch of up to five
// results held in a result buffer; the buffer drains one word per cycle while
// the receiver is ready. the first result is presented in the cycle after the
// byte is accepted. throughput: one input byte per cycle when it yields at
// most one result and the receiver is ready; a byte that yields several results
// holds off the next byte until its batch has left through the single master port.
// a new byte is taken in the same cycle the last word of the previous batch
// leaves, so back to back bytes run with no bubble.
// reset clears all parse state; the signature buffer holds garbage until a
// hard-drive record fills it. when the receiver stalls, the batch holds and
// the slave side stops taking bytes once the batch is not drained.
module boot_device_path_parser_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte[7:0]
  input  logic         s_axis_tlast,   // list_end
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // kind[1:0] path_byte[9:2] path_first[10] uuid_high[74:11] uuid_low[138:75]
  // uuid_found[139] stop_cause[141:140], zero fill to 144
  output logic [143:0] m_axis_tdata,
  output logic         m_axis_tlast    // run_last
);

  // parse state
  logic [15:0] off_q, len_q;
  logic [7:0]  typ_q, sub_q, tbl_q, pend_q;
  logic [7:0]  sig_q [16];
  logic [63:0] hi_q, lo_q;
  logic        seen_q, done_q, halt_q, any_q;
  logic [1:0]  code_q;

  // result batch
  bdpp_pkg::result_t res_q [5];
  logic [2:0] cnt_q, idx_q;

  logic acc, pop, drain_last;
  assign pop        = m_axis_tvalid && m_axis_tready;
  assign drain_last = pop && (idx_q + 3'd1 == cnt_q);
  assign s_axis_tready = (cnt_q == 3'd0) || drain_last;
  assign acc = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = cnt_q != 3'd0;
  assign m_axis_tdata  = {2'b00, res_q[idx_q][141:0]};
  assign m_axis_tlast  = res_q[idx_q].run_last;

  // combinational decode of one byte
  logic [15:0] off_d, len_d;
  logic [7:0]  typ_d, sub_d, tbl_d, pend_d;
  logic [63:0] hi_d, lo_d;
  logic        seen_d, done_d, halt_d, any_d, sig_we;
  logic [1:0]  code_d;
  logic [15:0] unit;
  logic        is_file, is_hd;
  bdpp_pkg::result_t r [5];
  logic [2:0]  n;
  logic [7:0]  b [3];
  logic [1:0]  nb;

  always_comb begin
    off_d = off_q; len_d = len_q; typ_d = typ_q; sub_d = sub_q; tbl_d = tbl_q;
    pend_d = pend_q; hi_d = hi_q; lo_d = lo_q; seen_d = seen_q; done_d = done_q;
    halt_d = halt_q; any_d = any_q; code_d = code_q; sig_we = 1'b0;
    n = 3'd0; nb = 2'd0;
    b[0] = 8'h00; b[1] = 8'h00; b[2] = 8'h00;
    for (int k = 0; k < 5; k++) r[k] = '0;
    unit = {s_axis_tdata, pend_q};
    is_file = typ_q == bdpp_pkg::TYPE_MEDIA && sub_q == bdpp_pkg::SUB_FILE;
    is_hd   = typ_q == bdpp_pkg::TYPE_MEDIA && sub_q == bdpp_pkg::SUB_HD;
    if (!halt_q) begin
      if (off_q == 16'd0) typ_d = s_axis_tdata;
      else if (off_q == 16'd1) sub_d = s_axis_tdata;
      else if (off_q == 16'd2) len_d = {8'h00, s_axis_tdata};
      else if (off_q == 16'd3) begin
        len_d = {s_axis_tdata, len_q[7:0]};
        if (len_d < 16'd4) begin
          halt_d = 1'b1; code_d = bdpp_pkg::STOP_LENGTH;
        end else if (typ_q == bdpp_pkg::TYPE_END && sub_q == bdpp_pkg::SUB_END) begin
          halt_d = 1'b1; code_d = bdpp_pkg::STOP_END;
        end else if (is_file) begin
          done_d = 1'b0; any_d = 1'b0; pend_d = 8'h00;
        end
      end else if (is_hd) begin
        if (off_q >= 16'd24 && off_q <= 16'd39) sig_we = 1'b1;
        else if (off_q == 16'd40) tbl_d = s_axis_tdata;
        else if (off_q == 16'd41 && tbl_q == bdpp_pkg::GPT_CODE &&
                 s_axis_tdata == bdpp_pkg::GPT_CODE) begin
          hi_d = {sig_q[3], sig_q[2], sig_q[1], sig_q[0],
                  sig_q[5], sig_q[4], sig_q[7], sig_q[6]};
          lo_d = {sig_q[8], sig_q[9], sig_q[10], sig_q[11],
                  sig_q[12], sig_q[13], sig_q[14], sig_q[15]};
          seen_d = 1'b1;
        end
      end else if (is_file && !done_q) begin
        if (!off_q[0]) pend_d = s_axis_tdata;
        else if (unit == 16'd0) begin
          r[0].kind = bdpp_pkg::KIND_DONE; r[0].path_first = !any_q;
          n = 3'd1; done_d = 1'b1;
        end else if (unit < 16'h0080) begin
          b[0] = unit[7:0]; nb = 2'd1;
        end else if (unit < 16'h0800) begin
          b[0] = 8'hc0 | {3'b000, unit[10:6]}; b[1] = 8'h80 | {2'b00, unit[5:0]};
          nb = 2'd2;
        end else begin
          b[0] = 8'he0 | {4'h0, unit[15:12]};
          b[1] = 8'h80 | {2'b00, unit[11:6]};
          b[2] = 8'h80 | {2'b00, unit[5:0]}; nb = 2'd3;
        end
      end
      for (int k = 0; k < 3; k++) begin
        if (k < nb) begin
          r[k].kind = bdpp_pkg::KIND_PATH;
          r[k].path_byte = (b[k] == 8'h5c) ? 8'h2f : b[k];
          r[k].path_first = (k == 0) && !any_q;
        end
      end
      if (nb != 2'd0) begin
        n = {1'b0, nb}; any_d = 1'b1;
      end
      if (!halt_d) begin
        if (off_q >= 16'd3 && off_q + 16'd1 >= len_d) begin
          if (is_file && !done_d) begin
            r[n].kind = bdpp_pkg::KIND_DONE; r[n].path_first = !any_d;
            n = n + 3'd1; done_d = 1'b1;
          end
          off_d = 16'd0;
        end else off_d = off_q + 16'd1;
      end
    end
    if (s_axis_tlast) begin
      if (!halt_d && off_d >= 16'd4 && is_file && !done_d) begin
        r[n].kind = bdpp_pkg::KIND_DONE; r[n].path_first = !any_d;
        n = n + 3'd1;
      end
      r[n].kind = bdpp_pkg::KIND_SUMMARY;
      r[n].uuid_high = hi_d; r[n].uuid_low = lo_d; r[n].uuid_found = seen_d;
      r[n].stop_cause = halt_d ? code_d : bdpp_pkg::STOP_LIST;
      n = n + 3'd1;
      off_d = '0; len_d = '0; typ_d = '0; sub_d = '0; tbl_d = '0; pend_d = '0;
      hi_d = '0; lo_d = '0; seen_d = 1'b0; done_d = 1'b0; halt_d = 1'b0;
      any_d = 1'b0; code_d = bdpp_pkg::STOP_LIST;
    end
    for (int k = 0; k < 5; k++) r[k].run_last = (n != 3'd0) && (3'(k) == n - 3'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0; len_q <= '0; typ_q <= '0; sub_q <= '0; tbl_q <= '0;
      pend_q <= '0; hi_q <= '0; lo_q <= '0; seen_q <= 1'b0; done_q <= 1'b0;
      halt_q <= 1'b0; any_q <= 1'b0; code_q <= bdpp_pkg::STOP_LIST;
      cnt_q <= '0; idx_q <= '0;
    end else begin
      if (acc) begin
        off_q <= off_d; len_q <= len_d; typ_q <= typ_d; sub_q <= sub_d;
        tbl_q <= tbl_d; pend_q <= pend_d; hi_q <= hi_d; lo_q <= lo_d;
        seen_q <= seen_d; done_q <= done_d; halt_q <= halt_d; any_q <= any_d;
        code_q <= code_d; cnt_q <= n; idx_q <= '0;
      end else if (drain_last) begin
        cnt_q <= '0; idx_q <= '0;
      end else if (pop) begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (acc) begin
      for (int k = 0; k < 5; k++) res_q[k] <= r[k];
      if (sig_we) sig_q[off_q[3:0] - 4'd8] <= s_axis_tdata;
    end
  end

  // batch index stays inside the batch
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> idx_q < cnt_q) else $error("index past batch");
  // bytes are only taken once the batch is drained
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && cnt_q != 3'd0) |-> drain_last)
    else $error("byte taken over live batch");
  // a summary is always the last word of its batch
  a_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1:0] == bdpp_pkg::KIND_SUMMARY) |-> m_axis_tlast)
    else $error("summary not last");

endmodule

/* verif/bdpp_checker.sv */
module bdpp_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [143:0] m_axis_tdata,
  input  logic         m_axis_tlast,
  output int           fail_count_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  pbyte;
    logic        first;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        found;
    logic [1:0]  cause;
    logic        last;
  } word_t;

  word_t expected_words[$];

  // predicted parser state
  logic [15:0] rec_off, rec_len;
  logic [7:0]  rec_type, rec_sub, table_byte, low_byte;
  logic [7:0]  sig[16];
  logic [63:0] uuid_hi, uuid_lo;
  logic        uuid_ok, done_path, stopped, any_path;
  logic [1:0]  stop_kind;

  function automatic void clear_parse();
    rec_off = 0; rec_len = 0; rec_type = 0; rec_sub = 0; table_byte = 0;
    low_byte = 0; uuid_hi = 0; uuid_lo = 0; uuid_ok = 0; done_path = 0;
    stopped = 0; any_path = 0; stop_kind = bdpp_pkg::STOP_LIST;
  endfunction

  function automatic void push_word(logic [1:0] k, logic [7:0] b, logic f,
                                    logic [63:0] h, logic [63:0] l, logic fd,
                                    logic [1:0] c);
    word_t w;
    w.kind = k; w.pbyte = b; w.first = f; w.hi = h; w.lo = l;
    w.found = fd; w.cause = c; w.last = 0;
    expected_words.push_back(w);
  endfunction

  function automatic void emit_path(logic [7:0] b);
    push_word(bdpp_pkg::KIND_PATH, (b == 8'h5c) ? 8'h2f : b, !any_path, 0, 0, 0,
              bdpp_pkg::STOP_LIST);
    any_path = 1;
  endfunction

  function automatic void finish_path();
    push_word(bdpp_pkg::KIND_DONE, 0, !any_path, 0, 0, 0, bdpp_pkg::STOP_LIST);
    done_path = 1;
  endfunction

  function automatic logic file_rec();
    return rec_type == bdpp_pkg::TYPE_MEDIA && rec_sub == bdpp_pkg::SUB_FILE;
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic eol);
    int start_cnt;
    logic [15:0] u;
    start_cnt = expected_words.size();
    if (!stopped) begin
      if (rec_off == 0) rec_type = b;
      else if (rec_off == 1) rec_sub = b;
      else if (rec_off == 2) rec_len = {8'h00, b};
      else if (rec_off == 3) begin
        rec_len[15:8] = b;
        if (rec_len < 4) begin
          stopped = 1; stop_kind = bdpp_pkg::STOP_LENGTH;
        end else if (rec_type == bdpp_pkg::TYPE_END && rec_sub == bdpp_pkg::SUB_END) begin
          stopped = 1; stop_kind = bdpp_pkg::STOP_END;
        end else if (file_rec()) begin
          done_path = 0; any_path = 0; low_byte = 0;
        end
      end else if (rec_type == bdpp_pkg::TYPE_MEDIA && rec_sub == bdpp_pkg::SUB_HD) begin
        if (rec_off >= 24 && rec_off <= 39) sig[rec_off - 24] = b;
        else if (rec_off == 40) table_byte = b;
        else if (rec_off == 41 && table_byte == bdpp_pkg::GPT_CODE &&
                 b == bdpp_pkg::GPT_CODE) begin
          // first three guid fields are little-endian
          uuid_hi = {sig[3], sig[2], sig[1], sig[0], sig[5], sig[4], sig[7], sig[6]};
          uuid_lo = {sig[8], sig[9], sig[10], sig[11], sig[12], sig[13], sig[14], sig[15]};
          uuid_ok = 1;
        end
      end else if (file_rec() && !done_path) begin
        if (!rec_off[0]) low_byte = b;
        else begin
          u = {b, low_byte};
          if (u == 0) finish_path();
          else if (u < 16'h80) emit_path(u[7:0]);
          else if (u < 16'h800) begin
            emit_path(8'hc0 | u[10:6]);
            emit_path(8'h80 | u[5:0]);
          end else begin
            emit_path(8'he0 | u[15:12]);
            emit_path(8'h80 | u[11:6]);
            emit_path(8'h80 | u[5:0]);
          end
        end
      end
      if (!stopped) begin
        if (rec_off >= 3 && {16'h0, rec_off} + 1 >= {16'h0, rec_len}) begin
          if (file_rec() && !done_path) finish_path();
          rec_off = 0;
        end else rec_off = rec_off + 1;
      end
    end
    if (eol) begin
      if (!stopped && rec_off >= 4 && file_rec() && !done_path) finish_path();
      push_word(bdpp_pkg::KIND_SUMMARY, 0, 0, uuid_hi, uuid_lo, uuid_ok,
                stopped ? stop_kind : bdpp_pkg::STOP_LIST);
      clear_parse();
    end
    if (expected_words.size() > start_cnt)
      expected_words[expected_words.size() - 1].last = 1;
  endfunction

  word_t got, want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parse();
      expected_words.delete();
      fail_count_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = m_axis_tdata[1:0]; got.pbyte = m_axis_tdata[9:2];
        got.first = m_axis_tdata[10]; got.hi = m_axis_tdata[74:11];
        got.lo = m_axis_tdata[138:75]; got.found = m_axis_tdata[139];
        got.cause = m_axis_tdata[141:140]; got.last = m_axis_tlast;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word kind=%0d byte=%h", $time, got.kind, got.pbyte);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_words.pop_front();
          if (got !== want || m_axis_tdata[143:142] !== 2'b00) begin
            $display({"%0t: mismatch expected kind=%0d byte=%h first=%b hi=%h lo=%h",
                      " found=%b cause=%0d last=%b"},
                     $time, want.kind, want.pbyte, want.first, want.hi, want.lo,
                     want.found, want.cause, want.last);
            $display({"%0t:          actual   kind=%0d byte=%h first=%b hi=%h lo=%h",
                      " found=%b cause=%0d last=%b"},
                     $time, got.kind, got.pbyte, got.first, got.hi, got.lo,
                     got.found, got.cause, got.last);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      // prediction after the pop so same-edge results stay ordered
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tlast);
    end
  end

  assign pending_o = expected_words.size();
endmodule

/* verif/tb_boot_device_path_parser_core.sv */
module tb_boot_device_path_parser_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 0;
  logic         s_axis_tlast = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [143:0] m_axis_tdata;
  logic         m_axis_tlast;
  int           fail_count, pending;
  int           cycles = 0;
  logic         sink_quiet = 0;

  always #4 clk_i = ~clk_i;

  boot_device_path_parser_core u_top (.*);

  bdpp_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // list bytes queued for sending, tlast flag alongside
  logic [7:0] list_bytes[$];
  logic       list_ends[$];

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void add(logic [7:0] b);
    list_bytes.push_back(b);
    list_ends.push_back(0);
  endfunction

  function automatic void mark_end();
    list_ends[list_ends.size() - 1] = 1;
  endfunction

  function automatic void add_header(logic [7:0] t, logic [7:0] s, logic [15:0] len);
    add(t); add(s); add(len[7:0]); add(len[15:8]);
  endfunction

  // hard-drive record, optionally gpt/guid, optionally cut short
  function automatic void add_hd(logic gpt, int len);
    add_header(bdpp_pkg::TYPE_MEDIA, bdpp_pkg::SUB_HD, len[15:0]);
    for (int i = 4; i < len; i++) begin
      if (i == 40) add(gpt ? bdpp_pkg::GPT_CODE : $urandom_range(0, 255));
      else if (i == 41) add(gpt ? bdpp_pkg::GPT_CODE : $urandom_range(0, 255));
      else add($urandom_range(0, 255));
    end
  endfunction

  // file-path record of utf-16 units; mix ascii, backslash, 2 and 3 byte units
  function automatic void add_file(int units, logic term, logic odd);
    logic [15:0] u;
    int len;
    len = 4 + 2 * units + (term ? 2 : 0) + (odd ? 1 : 0);
    add_header(bdpp_pkg::TYPE_MEDIA, bdpp_pkg::SUB_FILE, len[15:0]);
    for (int i = 0; i < units; i++) begin
      case ($urandom_range(0, 5))
        0: u = 16'h005c;
        1: u = $urandom_range(16'h80, 16'h7ff);
        2: u = $urandom_range(16'h800, 16'hffff);
        default: u = $urandom_range(1, 16'h7f);
      endcase
      add(u[7:0]); add(u[15:8]);
    end
    if (term) begin add(0); add(0); end
    if (odd) add($urandom_range(0, 255));
  endfunction

  function automatic void add_other();
    int len;
    len = $urandom_range(4, 10);
    add_header($urandom_range(1, 3), $urandom_range(0, 255), len[15:0]);
    for (int i = 4; i < len; i++) add($urandom_range(0, 255));
  endfunction

  function automatic void random_list();
    int n, r;
    n = $urandom_range(1, 4);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 9);
      if (r < 3) add_hd($urandom_range(0, 3) != 0, ($urandom_range(0, 4) == 0) ?
                         $urandom_range(5, 41) : 42);
      else if (r < 7) add_file($urandom_range(0, 5), $urandom_range(0, 1),
                               $urandom_range(0, 3) == 0);
      else add_other();
    end
    r = $urandom_range(0, 9);
    if (r < 4) add_header(bdpp_pkg::TYPE_END, bdpp_pkg::SUB_END, 16'd4);
    else if (r < 5) add_header($urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 3));
    else if (r < 6) add($urandom_range(0, 255));
    if (r < 5 && $urandom_range(0, 1)) add($urandom_range(0, 255));
    if (list_bytes.size() == 0) add(0);
    mark_end();
  endfunction

  // receiver stalls, with quiet stretches
  always @(negedge clk_i) begin
    if (sink_quiet || $urandom_range(0, 3) != 0) m_axis_tready <= 1;
    else m_axis_tready <= ($urandom_range(0, 9) < 4) ? 1'b0 : 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("boot_device_path_parser_core verification failed");
      $finish;
    end
  end

  task automatic send_all();
    int g;
    while (list_bytes.size() > 0) begin
      g = sink_quiet ? 0 : gap_len();
      if (g > 0) begin
        s_axis_tvalid <= 0;
        repeat (g) @(negedge clk_i);
      end
      s_axis_tvalid <= 1;
      s_axis_tdata <= list_bytes.pop_front();
      s_axis_tlast <= list_ends.pop_front();
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      @(negedge clk_i);
    end
    s_axis_tvalid <= 0;
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed: empty path, escaped chars, gpt capture, end record, short length
    add_file(0, 0, 0); add_hd(1, 42);
    add_header(bdpp_pkg::TYPE_END, bdpp_pkg::SUB_END, 16'd4); mark_end();
    add_file(2, 1, 1); add_header(8'hff, 8'h00, 16'd2); mark_end();
    add_header(bdpp_pkg::TYPE_MEDIA, bdpp_pkg::SUB_FILE, 16'd12);
    add(8'hff); add(8'hff); add(8'h5c); add(8'h00);
    add(8'hab); mark_end();
    send_all();

    // hold off until everything has drained
    wait (pending == 0);
    repeat (10) @(negedge clk_i);

    while (list_bytes.size() == 0 && cycles < CYCLE_LIMIT) begin
      for (int i = 0; i < 40; i++) begin
        random_list();
        if (list_bytes.size() > 200) break;
      end
      break;
    end
    sink_quiet = 0;
    send_all();
    sink_quiet = 1;
    repeat (3) begin random_list(); end
    send_all();
    sink_quiet = 0;

    wait (pending == 0);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) $display("boot_device_path_parser_core verification clean");
    else $display("boot_device_path_parser_core verification failed");
    $finish;
  end
endmodule

/* boot_device_path_parser_core.f */
rtl/bdpp_pkg.sv
rtl/boot_device_path_parser_core.sv
verif/bdpp_checker.sv
verif/tb_boot_device_path_parser_core.sv
